@@ design/assert_macros.svh @@
// assertion macros used by the led driver chain top level
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// property must hold at every clock edge outside reset
`define ASSERT_HOLDS(lbl, clk, rst, prop) \
   lbl: assert property (@(posedge clk) disable iff (rst) (prop)) \
      else $error("%m: property violated");

// expression must never be true outside reset
`define ASSERT_NEVER(lbl, clk, rst, expr) \
   lbl: assert property (@(posedge clk) disable iff (rst) !(expr)) \
      else $error("%m: forbidden condition seen");

`else

`define ASSERT_HOLDS(lbl, clk, rst, prop)
`define ASSERT_NEVER(lbl, clk, rst, expr)

`endif

`endif

@@ design/ldcs_pkg.sv @@
// shared constants, types and channel ordering for the led driver chain shifter
`timescale 1ns / 1ps

package ldcs_pkg;

   localparam int CHIPS_DEF = 12;
   localparam int ROWS      = 16;

   localparam logic [15:0] IN_MAX  = 16'd65280;
   localparam logic [11:0] OUT_MAX = 12'd4095;
   // 65280 * 256 = 255 * 2^16
   localparam logic [8:0]  DIV_K   = 9'd255;

   localparam logic [2:0] ACT_SET_PIXEL = 3'd0;
   localparam logic [2:0] ACT_CLEAR     = 3'd1;
   localparam logic [2:0] ACT_FRAME     = 3'd2;
   localparam logic [2:0] ACT_CONFIG    = 3'd3;
   localparam logic [2:0] ACT_TICK      = 3'd4;

   localparam logic [1:0] CSR_THROTTLE = 2'd0;
   localparam logic [1:0] CSR_LIGHTS   = 2'd1;
   localparam logic [1:0] CSR_MODE     = 2'd2;
   localparam logic [1:0] CSR_GAIN     = 2'd3;

   localparam logic [2:0] CH_RED_ONE   = 3'd0;
   localparam logic [2:0] CH_RED_TWO   = 3'd1;
   localparam logic [2:0] CH_GREEN_ONE = 3'd2;
   localparam logic [2:0] CH_BLUE_ONE  = 3'd3;
   localparam logic [2:0] CH_AMBER_ONE = 3'd4;
   localparam logic [2:0] CH_AMBER_TWO = 3'd5;
   localparam logic [2:0] CH_LIME_ONE  = 3'd6;
   localparam logic [2:0] CH_LIME_TWO  = 3'd7;

   typedef enum logic [1:0] {
      KIND_IDLE,
      KIND_FRAME,
      KIND_CONFIG
   } kind_type;

   typedef enum logic [2:0] {
      MS_CLEAR,
      MS_READY,
      MS_FETCH,
      MS_SCALE_START,
      MS_SCALE_WAIT
   } main_state_type;

   typedef enum logic [1:0] {
      SC_IDLE,
      SC_PREP,
      SC_MUL,
      SC_DIV
   } scale_phase_type;

   // channel written to row offset k of the odd or even row group
   function automatic logic [2:0] chan_sel(input logic odd, input logic [2:0] k);
      logic [2:0] ch;
      unique case (k)
         3'd0: ch = CH_GREEN_ONE;
         3'd1: ch = CH_BLUE_ONE;
         3'd2: ch = CH_AMBER_TWO;
         3'd3: ch = CH_AMBER_ONE;
         3'd4: ch = odd ? CH_RED_TWO : CH_LIME_TWO;
         3'd5: ch = odd ? CH_RED_ONE : CH_LIME_ONE;
         3'd6: ch = odd ? CH_LIME_TWO : CH_RED_TWO;
         3'd7: ch = odd ? CH_LIME_ONE : CH_RED_ONE;
         default: ch = CH_GREEN_ONE;
      endcase
      return ch;
   endfunction

endpackage

@@ design/ldcs_scaler.sv @@
// bit-serial channel scaler: clamp, multiply by 4095 and throttle, divide by 255 * 2^16
`timescale 1ns / 1ps

module ldcs_scaler (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   input  logic [15:0] value,
   input  logic [15:0] throttle,
   output logic        done,
   output logic [11:0] result
);

   import ldcs_pkg::*;

   scale_phase_type phase_ff, phase_in;
   logic [15:0] vc_ff, vc_in;
   logic [27:0] m_ff, m_in;
   logic [43:0] p_ff, p_in;
   logic [7:0]  rem_ff, rem_in;
   logic [4:0]  cnt_ff, cnt_in;
   logic        done_ff, done_in;

   logic [28:0] sum;
   logic [8:0]  r9;
   logic        ge;

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= SC_IDLE;
         cnt_ff   <= '0;
         done_ff  <= 1'b0;
      end else begin
         phase_ff <= phase_in;
         cnt_ff   <= cnt_in;
         done_ff  <= done_in;
      end
      vc_ff  <= vc_in;
      m_ff   <= m_in;
      p_ff   <= p_in;
      rem_ff <= rem_in;
   end

   always_comb begin
      phase_in = phase_ff;
      vc_in    = vc_ff;
      m_in     = m_ff;
      p_in     = p_ff;
      rem_in   = rem_ff;
      cnt_in   = cnt_ff;
      done_in  = 1'b0;
      sum      = {1'b0, p_ff[43:16]} + (p_ff[0] ? {1'b0, m_ff} : 29'd0);
      r9       = {rem_ff, p_ff[43]};
      ge       = (r9 >= DIV_K);
      unique case (phase_ff)
         SC_IDLE: begin
            if (start) begin
               vc_in    = (value > IN_MAX) ? IN_MAX : value;
               p_in     = {28'd0, throttle};
               phase_in = SC_PREP;
            end
         end
         SC_PREP: begin
            m_in     = {vc_ff, 12'd0} - {12'd0, vc_ff};
            cnt_in   = '0;
            phase_in = SC_MUL;
         end
         SC_MUL: begin
            p_in = {sum, p_ff[15:1]};
            if (cnt_ff == 5'd15) begin
               cnt_in   = '0;
               rem_in   = '0;
               phase_in = SC_DIV;
            end else begin
               cnt_in = cnt_ff + 5'd1;
            end
         end
         SC_DIV: begin
            rem_in       = ge ? 8'(r9 - DIV_K) : r9[7:0];
            p_in[43:16]  = {p_ff[42:16], ge};
            if (cnt_ff == 5'd27) begin
               cnt_in   = '0;
               done_in  = 1'b1;
               phase_in = SC_IDLE;
            end else begin
               cnt_in = cnt_ff + 5'd1;
            end
         end
         default: phase_in = SC_IDLE;
      endcase
   end

   assign done   = done_ff;
   assign result = (|p_ff[43:28]) ? OUT_MAX : p_ff[27:16];

endmodule

@@ design/ldcs_store.sv @@
// frame store memory, one write port and one registered read port
`timescale 1ns / 1ps

module ldcs_store #(
   parameter int DEPTH = 192
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [11:0]              wdata,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [11:0]              rdata
);

   logic [11:0] mem [DEPTH];
   logic [11:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      rdata_ff <= mem[raddr];
   end

   assign rdata = rdata_ff;

endmodule

@@ design/led_driver_chain_shifter.sv @@
// top level: command decode, frame store control and serial bit shifter
// every transaction yields one result in the output register in the cycle after acceptance
// ticks: one per cycle if rsp is taken; a frame pauses per 16-bit word for the store read
// set pixel: 8 channels through the bit-serial scaler, one after another
// clear store and reset: a clearing pass over all 16*CHIPS store words, one word per cycle
// reset (synchronous, active high) idles the transfer and restores the register defaults
`timescale 1ns / 1ps
`include "assert_macros.svh"

module led_driver_chain_shifter #(
   parameter int CHIPS = ldcs_pkg::CHIPS_DEF
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [2:0]  req_action,
   input  logic [4:0]  req_pixel_index,
   input  logic        req_pixel_enable,
   input  logic [15:0] req_red_one,
   input  logic [15:0] req_red_two,
   input  logic [15:0] req_green_one,
   input  logic [15:0] req_blue_one,
   input  logic [15:0] req_amber_one,
   input  logic [15:0] req_amber_two,
   input  logic [15:0] req_lime_one,
   input  logic [15:0] req_lime_two,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic        rsp_serial_data,
   output logic        rsp_clock_pulse,
   output logic        rsp_latch_enable,
   output logic        rsp_busy_res,
   output logic        rsp_transfer_done,
   output logic        rsp_rejected,
   input  logic        csr_wr_en,
   input  logic [1:0]  csr_index,
   input  logic [15:0] csr_wr_data
);

   import ldcs_pkg::*;

   localparam int STORE_WORDS = ROWS * CHIPS;
   localparam int AW          = $clog2(STORE_WORDS);
   localparam int SW          = (CHIPS > 1) ? $clog2(CHIPS) : 1;
   localparam int PIX_MAX     = 2 * CHIPS;

   main_state_type state_ff, state_in;
   kind_type       kind_ff, kind_in;
   logic [AW-1:0]  addr_ff, addr_in;
   logic [SW-1:0]  slot_ff, slot_in;
   logic [3:0]     row_ff, row_in;
   logic [3:0]     bit_ff, bit_in;
   logic [15:0]    shift_ff, shift_in;
   logic [AW-1:0]  clr_ff, clr_in;
   logic [15:0]    ch_ff [8];
   logic [15:0]    ch_in [8];
   logic           zero_ff, zero_in;
   logic           odd_ff, odd_in;
   logic [SW-1:0]  pslot_ff, pslot_in;
   logic [2:0]     k_ff, k_in;

   logic [15:0]    throttle_ff;
   logic           lights_ff;
   logic [15:0]    mode_ff;
   logic [7:0]     gain_ff;

   logic           rsp_valid_ff, rsp_valid_in;
   logic           sdata_ff, sdata_in;
   logic           clk_ff, clk_in;
   logic           le_ff, le_in;
   logic           busy_ff, busy_in;
   logic           done_ff, done_in;
   logic           rej_ff, rej_in;

   logic           accept;
   logic           busy;
   logic           last_word;
   logic [15:0]    cur_word;
   logic [15:0]    cfg_word;
   logic           st_we;
   logic [AW-1:0]  st_waddr;
   logic [11:0]    st_wdata;
   logic [11:0]    st_rdata;
   logic [AW-1:0]  wr_addr;
   logic           sc_start;
   logic           sc_done;
   logic [11:0]    sc_result;

   ldcs_store #(
      .DEPTH(STORE_WORDS)
   ) u_store (
      .clock(clock),
      .we   (st_we),
      .waddr(st_waddr),
      .wdata(st_wdata),
      .raddr(addr_ff),
      .rdata(st_rdata)
   );

   ldcs_scaler u_scaler (
      .clock   (clock),
      .reset   (reset),
      .start   (sc_start),
      .value   (ch_ff[chan_sel(odd_ff, k_ff)]),
      .throttle(throttle_ff),
      .done    (sc_done),
      .result  (sc_result)
   );

   assign req_ready = (state_ff == MS_READY) && (!rsp_valid_ff || rsp_ready);
   assign accept    = req_valid && req_ready;
   assign busy      = (kind_ff != KIND_IDLE);
   assign sc_start  = (state_ff == MS_SCALE_START);
   assign last_word = (int'(slot_ff) == CHIPS - 1);
   assign cfg_word  = mode_ff | {6'd0, gain_ff, 2'd0};
   assign cur_word  = (bit_ff != 4'd0) ? shift_ff
                    : (kind_ff == KIND_FRAME) ? {4'd0, st_rdata} : cfg_word;
   assign wr_addr   = AW'(int'({~odd_ff, k_ff}) * CHIPS + int'(pslot_ff));

   always_comb begin
      st_we    = 1'b0;
      st_waddr = clr_ff;
      st_wdata = '0;
      if (state_ff == MS_CLEAR) begin
         st_we = 1'b1;
      end else if (state_ff == MS_SCALE_WAIT && sc_done) begin
         st_we    = 1'b1;
         st_waddr = wr_addr;
         st_wdata = zero_ff ? 12'd0 : sc_result;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= MS_CLEAR;
         kind_ff      <= KIND_IDLE;
         addr_ff      <= '0;
         slot_ff      <= '0;
         row_ff       <= '0;
         bit_ff       <= '0;
         shift_ff     <= '0;
         clr_ff       <= '0;
         k_ff         <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         kind_ff      <= kind_in;
         addr_ff      <= addr_in;
         slot_ff      <= slot_in;
         row_ff       <= row_in;
         bit_ff       <= bit_in;
         shift_ff     <= shift_in;
         clr_ff       <= clr_in;
         k_ff         <= k_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      ch_ff    <= ch_in;
      zero_ff  <= zero_in;
      odd_ff   <= odd_in;
      pslot_ff <= pslot_in;
      sdata_ff <= sdata_in;
      clk_ff   <= clk_in;
      le_ff    <= le_in;
      busy_ff  <= busy_in;
      done_ff  <= done_in;
      rej_ff   <= rej_in;
   end

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         throttle_ff <= 16'd256;
         lights_ff   <= 1'b0;
         mode_ff     <= 16'd0;
         gain_ff     <= 8'd150;
      end else if (csr_wr_en) begin
         unique case (csr_index)
            CSR_THROTTLE: throttle_ff <= csr_wr_data;
            CSR_LIGHTS:   lights_ff   <= csr_wr_data[0];
            CSR_MODE:     mode_ff     <= csr_wr_data;
            CSR_GAIN:     gain_ff     <= csr_wr_data[7:0];
            default:      gain_ff     <= gain_ff;
         endcase
      end
   end

   always_comb begin
      state_in = state_ff;
      kind_in  = kind_ff;
      addr_in  = addr_ff;
      slot_in  = slot_ff;
      row_in   = row_ff;
      bit_in   = bit_ff;
      shift_in = shift_ff;
      clr_in   = clr_ff;
      ch_in    = ch_ff;
      zero_in  = zero_ff;
      odd_in   = odd_ff;
      pslot_in = pslot_ff;
      k_in     = k_ff;
      sdata_in = sdata_ff;
      clk_in   = clk_ff;
      le_in    = le_ff;
      busy_in  = busy_ff;
      done_in  = done_ff;
      rej_in   = rej_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;

      unique case (state_ff)
         MS_CLEAR: begin
            if (clr_ff == AW'(STORE_WORDS - 1)) begin
               clr_in   = '0;
               state_in = MS_READY;
            end else begin
               clr_in = clr_ff + 1'b1;
            end
         end
         MS_FETCH: state_in = MS_READY;
         MS_SCALE_START: state_in = MS_SCALE_WAIT;
         MS_SCALE_WAIT: begin
            if (sc_done) begin
               if (k_ff == 3'd7) begin
                  k_in     = '0;
                  state_in = MS_READY;
               end else begin
                  k_in     = k_ff + 3'd1;
                  state_in = MS_SCALE_START;
               end
            end
         end
         MS_READY: begin
            if (accept) begin
               rsp_valid_in = 1'b1;
               sdata_in     = 1'b0;
               clk_in       = 1'b0;
               le_in        = 1'b0;
               done_in      = 1'b0;
               rej_in       = 1'b0;
               busy_in      = busy;
               if (req_action == ACT_TICK) begin
                  if (busy) begin
                     sdata_in = cur_word[15];
                     clk_in   = 1'b1;
                     shift_in = {cur_word[14:0], 1'b0};
                     if (kind_ff == KIND_FRAME) begin
                        le_in = last_word && ((row_ff != 4'd15) ? (bit_ff == 4'd15)
                                                               : (bit_ff >= 4'd13));
                     end else begin
                        le_in = last_word && (bit_ff >= 4'd5);
                     end
                     if (bit_ff == 4'd15) begin
                        bit_in = '0;
                        if (last_word && (kind_ff == KIND_CONFIG || row_ff == 4'd15)) begin
                           done_in = 1'b1;
                           kind_in = KIND_IDLE;
                           addr_in = '0;
                           slot_in = '0;
                           row_in  = '0;
                        end else begin
                           if (last_word) begin
                              slot_in = '0;
                              row_in  = row_ff + 4'd1;
                           end else begin
                              slot_in = slot_ff + 1'b1;
                           end
                           if (kind_ff == KIND_FRAME) begin
                              addr_in  = addr_ff + 1'b1;
                              state_in = MS_FETCH;
                           end
                        end
                     end else begin
                        bit_in = bit_ff + 4'd1;
                     end
                  end
               end else if (req_action > ACT_TICK || busy) begin
                  rej_in = 1'b1;
               end else if (req_action == ACT_SET_PIXEL) begin
                  if (req_pixel_index == 5'd0 || int'(req_pixel_index) > PIX_MAX) begin
                     rej_in = 1'b1;
                  end else begin
                     ch_in[CH_RED_ONE]   = req_red_one;
                     ch_in[CH_RED_TWO]   = req_red_two;
                     ch_in[CH_GREEN_ONE] = req_green_one;
                     ch_in[CH_BLUE_ONE]  = req_blue_one;
                     ch_in[CH_AMBER_ONE] = req_amber_one;
                     ch_in[CH_AMBER_TWO] = req_amber_two;
                     ch_in[CH_LIME_ONE]  = req_lime_one;
                     ch_in[CH_LIME_TWO]  = req_lime_two;
                     zero_in  = lights_ff || !req_pixel_enable;
                     odd_in   = req_pixel_index[0];
                     pslot_in = SW'((int'(req_pixel_index) - 1) >> 1);
                     k_in     = '0;
                     state_in = MS_SCALE_START;
                  end
               end else if (req_action == ACT_CLEAR) begin
                  clr_in   = '0;
                  state_in = MS_CLEAR;
               end else begin
                  kind_in  = (req_action == ACT_FRAME) ? KIND_FRAME : KIND_CONFIG;
                  addr_in  = '0;
                  slot_in  = '0;
                  row_in   = '0;
                  bit_in   = '0;
                  shift_in = '0;
                  busy_in  = 1'b1;
                  if (req_action == ACT_FRAME) begin
                     state_in = MS_FETCH;
                  end
               end
            end
         end
         default: state_in = MS_READY;
      endcase
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_serial_data   = sdata_ff;
   assign rsp_clock_pulse   = clk_ff;
   assign rsp_latch_enable  = le_ff;
   assign rsp_busy_res      = busy_ff;
   assign rsp_transfer_done = done_ff;
   assign rsp_rejected      = rej_ff;

   // no pixel scaling or clearing while a transfer runs
   `ASSERT_HOLDS(a_no_work_in_transfer, clock, reset, (kind_ff != KIND_IDLE) |-> (state_ff != MS_SCALE_START && state_ff != MS_SCALE_WAIT && state_ff != MS_CLEAR))
   // the store is never written while a transfer runs
   `ASSERT_NEVER(a_no_write_in_transfer, clock, reset, st_we && kind_ff != KIND_IDLE)
   // in a frame, the read address has settled before a tick can be taken
   `ASSERT_HOLDS(a_fetch_settled, clock, reset, (state_ff == MS_READY && kind_ff == KIND_FRAME) |-> $stable(addr_ff))
   // a finished transfer leaves the shifter idle with counters cleared
   `ASSERT_HOLDS(a_done_idles, clock, reset, (accept && req_action == ACT_TICK && busy && bit_ff == 4'd15 && last_word && (kind_ff == KIND_CONFIG || row_ff == 4'd15)) |=> (kind_ff == KIND_IDLE && addr_ff == '0 && bit_ff == 4'd0))

endmodule
